>>> hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// types and constants shared by the subarray sum counter
// ----------------------------------------------------------------------------
`default_nettype none
package ssc_pkg;
  localparam int MaxItems     = 4096;
  localparam int TableEntries = 8192;
  localparam int SlotW        = $clog2(TableEntries);
  localparam int IdxW         = $clog2(MaxItems + 1);
  localparam int KeyW         = 28;
  localparam int CountW       = 13;
  localparam int TotalW       = 24;
  localparam int EntryW       = 1 + KeyW + CountW;
  localparam int ProbeW       = $clog2(TableEntries + 1);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [TotalW-1:0] run_count;
    logic              final_res;
    logic              length_error;
  } out_item_t;
endpackage
`default_nettype wire

>>> hw/rtl/subarray_sum_count.sv
// ----------------------------------------------------------------------------
// subarray_sum_count
// counts contiguous runs whose sum equals target_sum, via a probed hash table
// ----------------------------------------------------------------------------
// each item runs a lookup probe sequence, then an insert probe sequence, each
//   probe a table read and a check; one item at a time, bounded by the single table port
// after reset and after each end of sequence the table is swept clear, one
//   slot a cycle, seeding key 0 in slot 0, while in_ready stays low
// reset: synchronous active low, target_sum returns to 0
`default_nettype none
module subarray_sum_count
  import ssc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic signed [KeyW-1:0] cfg_target_sum
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LRD   = 3'd2;
  localparam logic [2:0] S_LCHK  = 3'd3;
  localparam logic [2:0] S_IRD   = 3'd4;
  localparam logic [2:0] S_ICHK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]               state_r;
  logic signed [KeyW-1:0]   target_r;
  logic signed [KeyW-1:0]   prefix_r;
  logic [TotalW-1:0]        total_r;
  logic [IdxW-1:0]          index_r;
  logic signed [KeyW-1:0]   key_r;
  logic                     diff_ok_r;
  logic [SlotW-1:0]         slot_r;
  logic [ProbeW-1:0]        probes_r;
  logic                     last_r;
  logic                     err_r;

  logic                     ram_we;
  logic [SlotW-1:0]         ram_addr;
  logic [EntryW-1:0]        ram_wdata;
  logic [EntryW-1:0]        ram_rdata;
  logic                     e_valid;
  logic [KeyW-1:0]          e_key;
  logic [CountW-1:0]        e_count;
  logic signed [KeyW:0]     sum_w;
  logic signed [KeyW:0]     diff_w;
  logic [TotalW:0]          tsum_w;

  assign {e_valid, e_key, e_count} = ram_rdata;
  assign sum_w  = KeyW'(prefix_r + KeyW'(in_data.sample)) - (KeyW+1)'(target_r);
  assign diff_w = sum_w;
  assign tsum_w = {1'b0, total_r} + (TotalW+1)'(e_count);

  ssc_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{run_count: total_r, final_res: last_r, length_error: err_r};

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      if (slot_r == '0) begin
        ram_wdata = {1'b1, KeyW'(0), CountW'(1)};
      end
    end else if (state_r == S_ICHK) begin
      if (!e_valid) begin
        ram_we    = (probes_r != '0);
        ram_wdata = {1'b1, key_r, CountW'(1)};
      end else if (e_key == key_r) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, key_r, (e_count == '1) ? e_count : e_count + 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      target_r <= '0;
      slot_r   <= '0;
      prefix_r <= '0;
      total_r  <= '0;
      index_r  <= '0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_target_sum;
      end
      case (state_r)
        S_CLEAR: begin
          slot_r <= slot_r + 1'b1;
          if (slot_r == SlotW'(TableEntries - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_data.end_of_sequence;
            if (index_r >= IdxW'(MaxItems)) begin
              err_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              err_r     <= 1'b0;
              prefix_r  <= KeyW'(prefix_r + KeyW'(in_data.sample));
              key_r     <= diff_w[KeyW-1:0];
              diff_ok_r <= (diff_w[KeyW] == diff_w[KeyW-1]);
              slot_r    <= diff_w[SlotW-1:0];
              probes_r  <= ProbeW'(TableEntries);
              index_r   <= index_r + 1'b1;
              state_r   <= S_LRD;
            end
          end
        end
        S_LRD: state_r <= S_LCHK;
        S_LCHK: begin
          if (!diff_ok_r || !e_valid || e_key == key_r || probes_r == ProbeW'(1)) begin
            if (diff_ok_r && e_valid && e_key == key_r) begin
              total_r <= tsum_w[TotalW] ? '1 : tsum_w[TotalW-1:0];
            end
            key_r    <= prefix_r;
            slot_r   <= prefix_r[SlotW-1:0];
            probes_r <= ProbeW'(TableEntries);
            state_r  <= S_IRD;
          end else begin
            slot_r   <= slot_r + 1'b1;
            probes_r <= probes_r - 1'b1;
            state_r  <= S_LRD;
          end
        end
        S_IRD: state_r <= S_ICHK;
        S_ICHK: begin
          if (!e_valid || e_key == key_r || probes_r <= ProbeW'(1)) begin
            state_r <= S_OUT;
          end else begin
            slot_r   <= slot_r + 1'b1;
            probes_r <= probes_r - 1'b1;
            state_r  <= S_IRD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (last_r) begin
              prefix_r <= '0;
              total_r  <= '0;
              index_r  <= '0;
              slot_r   <= '0;
              state_r  <= S_CLEAR;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ssc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire
